// ===== hdl/pwd_pkg.sv =====
// Shared widths and register indexes for the proximity warning driver.
// No dependencies; used by pwd_div and proximity_warning_driver.
package pwd_pkg;

    localparam int DIST_W = 10;  // distance fields and distance registers
    localparam int TIME_W = 32;  // timestamps and time registers
    localparam int DUTY_W = 8;   // PWM duties
    localparam int NUM_W  = 18;  // magnitude of (d - max) * span, at most 1023 * 255
    localparam int CFG_W  = 32;  // config write data, widest register
    localparam int IDX_W  = 3;   // config register index

    localparam logic [IDX_W-1:0] REG_DANGER   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX      = 3'd1;
    localparam logic [IDX_W-1:0] REG_DELTA    = 3'd2;
    localparam logic [IDX_W-1:0] REG_STIME    = 3'd3;
    localparam logic [IDX_W-1:0] REG_COOLDOWN = 3'd4;
    localparam logic [IDX_W-1:0] REG_BFLOOR   = 3'd5;
    localparam logic [IDX_W-1:0] REG_VFLOOR   = 3'd6;
    localparam logic [IDX_W-1:0] REG_VCEIL    = 3'd7;

    localparam logic [DIST_W-1:0] NO_ECHO_CM = 10'd999;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 8'd255;

endpackage

// ===== hdl/proximity_warning_driver.sv =====
// Proximity warning driver: stability tracking, buzzer/vibration duty maps, alert pulse.
// Depends on pwd_pkg and pwd_div.
//
// One sample at a time. A sample that is beyond max_cm, or that finds the object stable,
// goes from S_ALRT straight to S_OUT with both duties zero. Otherwise both duties are
// computed with one shared 18-step serial divider, run once per duty. When danger_cm
// equals max_cm the divider is skipped and the duty takes its top value. in_stall stays
// high from acceptance until the result is loaded into the output register; the result
// there waits for out_stall to drop.
module proximity_warning_driver
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pwd_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pwd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pwd_pkg::DIST_W-1:0]    distance_cm,
    input  logic [pwd_pkg::TIME_W-1:0]    now_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pwd_pkg::DUTY_W-1:0]    buzzer_duty,
    output logic [pwd_pkg::DUTY_W-1:0]    vibration_duty,
    output logic                          object_stable,
    output logic                          alert_pulse
);

    localparam int DW = pwd_pkg::DIST_W;
    localparam int TW = pwd_pkg::TIME_W;
    localparam int UW = pwd_pkg::DUTY_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_HOLD = 3'd2;
    localparam logic [2:0] S_ALRT = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // configuration
    logic [DW-1:0] danger_reg, max_reg, delta_reg;
    logic [TW-1:0] stime_reg, cool_reg;
    logic [UW-1:0] bfloor_reg, vfloor_reg, vceil_reg;

    // sequencer and state
    logic [2:0]    state_reg, state_next;
    logic [DW-1:0] d_reg, d_next;
    logic [TW-1:0] now_reg, now_next;
    logic [DW-1:0] ref_reg, ref_next;
    logic [TW-1:0] chg_reg, chg_next;
    logic          stable_reg, stable_next;
    logic [TW-1:0] alert_t_reg, alert_t_next;
    logic          pulse_reg, pulse_next;
    logic          sel_reg, sel_next;   // 0: buzzer, 1: vibration
    logic          neg_reg, neg_next;
    logic [UW-1:0] buzz_reg, buzz_next;
    logic [UW-1:0] vibe_reg, vibe_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [UW-1:0] buzz_out_reg, buzz_out_next;
    logic [UW-1:0] vibe_out_reg, vibe_out_next;
    logic          stab_out_reg, stab_out_next;
    logic          pulse_out_reg, pulse_out_next;

    // datapath
    logic [DW-1:0]          diff;
    logic [TW-1:0]          elapsed;
    logic [UW-1:0]          lo, hi;
    logic signed [DW:0]     dd;
    logic signed [DW:0]     den;
    logic signed [UW:0]     span;
    logic signed [19:0]     prod;
    logic [19:0]            prod_mag;
    logic [DW:0]            den_mag;
    logic signed [19:0]     q_s;
    logic signed [19:0]     res;
    logic [UW-1:0]          res_sat;
    logic                   div_start;
    logic                   div_done;
    logic [pwd_pkg::NUM_W-1:0] quotient;
    logic                   store;
    logic [UW-1:0]          duty_val;

    pwd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[pwd_pkg::NUM_W-1:0]),
        .divisor  (den_mag[DW-1:0]),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        diff     = (d_reg > ref_reg) ? d_reg - ref_reg : ref_reg - d_reg;
        lo       = sel_reg ? vfloor_reg : bfloor_reg;
        hi       = sel_reg ? vceil_reg : pwd_pkg::DUTY_MAX;
        dd       = $signed({1'b0, d_reg}) - $signed({1'b0, max_reg});
        den      = $signed({1'b0, danger_reg}) - $signed({1'b0, max_reg});
        span     = $signed({1'b0, hi}) - $signed({1'b0, lo});
        prod     = dd * span;
        prod_mag = prod[19] ? 20'(-prod) : 20'(prod);
        den_mag  = den[DW] ? (DW+1)'(-den) : (DW+1)'(den);
        q_s      = $signed({2'b00, quotient});
        res      = $signed({12'd0, lo}) + (neg_reg ? -q_s : q_s);
        if (res < 0)
            res_sat = '0;
        else if (res > 20'sd255)
            res_sat = pwd_pkg::DUTY_MAX;
        else
            res_sat = res[UW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        d_next         = d_reg;
        now_next       = now_reg;
        ref_next       = ref_reg;
        chg_next       = chg_reg;
        stable_next    = stable_reg;
        alert_t_next   = alert_t_reg;
        pulse_next     = pulse_reg;
        sel_next       = sel_reg;
        neg_next       = neg_reg;
        buzz_next      = buzz_reg;
        vibe_next      = vibe_reg;
        out_valid_next = out_valid_reg;
        buzz_out_next  = buzz_out_reg;
        vibe_out_next  = vibe_out_reg;
        stab_out_next  = stab_out_reg;
        pulse_out_next = pulse_out_reg;
        elapsed        = '0;
        div_start      = 1'b0;
        store          = 1'b0;
        duty_val       = res_sat;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    d_next     = distance_cm;
                    now_next   = now_ms;
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (diff > delta_reg)
                begin
                    ref_next    = d_reg;
                    chg_next    = now_reg;
                    stable_next = 1'b0;
                end
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                elapsed = now_reg - chg_reg;
                if (elapsed > stime_reg)
                    stable_next = 1'b1;
                state_next = S_ALRT;
            end
            S_ALRT:
            begin
                elapsed    = now_reg - alert_t_reg;
                pulse_next = 1'b0;
                if (d_reg <= danger_reg && !stable_reg && elapsed > cool_reg)
                begin
                    pulse_next   = 1'b1;
                    alert_t_next = now_reg;
                end
                sel_next = 1'b0;
                if (d_reg > max_reg || stable_reg)
                begin
                    buzz_next  = '0;
                    vibe_next  = '0;
                    state_next = S_OUT;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (den == 0)
                begin
                    // flat line: duty takes its top value
                    store    = 1'b1;
                    duty_val = hi;
                end
                else
                begin
                    neg_next   = prod[19] ^ den[DW];
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                store = 1'b1;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    buzz_out_next  = buzz_reg;
                    vibe_out_next  = vibe_reg;
                    stab_out_next  = stable_reg;
                    pulse_out_next = pulse_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (store)
        begin
            if (!sel_reg)
            begin
                buzz_next  = (d_reg <= danger_reg) ? pwd_pkg::DUTY_MAX : duty_val;
                sel_next   = 1'b1;
                state_next = S_MUL;
            end
            else
            begin
                vibe_next  = duty_val;
                state_next = S_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ref_reg       <= pwd_pkg::NO_ECHO_CM;
            chg_reg       <= '0;
            stable_reg    <= 1'b0;
            alert_t_reg   <= '0;
            out_valid_reg <= 1'b0;
            danger_reg    <= 10'd50;
            max_reg       <= 10'd200;
            delta_reg     <= 10'd10;
            stime_reg     <= 32'd5000;
            cool_reg      <= 32'd60000;
            bfloor_reg    <= 8'd50;
            vfloor_reg    <= 8'd20;
            vceil_reg     <= 8'd60;
        end
        else
        begin
            state_reg     <= state_next;
            ref_reg       <= ref_next;
            chg_reg       <= chg_next;
            stable_reg    <= stable_next;
            alert_t_reg   <= alert_t_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pwd_pkg::REG_DANGER:   danger_reg <= cfg_data[DW-1:0];
                    pwd_pkg::REG_MAX:      max_reg    <= cfg_data[DW-1:0];
                    pwd_pkg::REG_DELTA:    delta_reg  <= cfg_data[DW-1:0];
                    pwd_pkg::REG_STIME:    stime_reg  <= cfg_data[TW-1:0];
                    pwd_pkg::REG_COOLDOWN: cool_reg   <= cfg_data[TW-1:0];
                    pwd_pkg::REG_BFLOOR:   bfloor_reg <= cfg_data[UW-1:0];
                    pwd_pkg::REG_VFLOOR:   vfloor_reg <= cfg_data[UW-1:0];
                    pwd_pkg::REG_VCEIL:    vceil_reg  <= cfg_data[UW-1:0];
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg         <= d_next;
        now_reg       <= now_next;
        pulse_reg     <= pulse_next;
        sel_reg       <= sel_next;
        neg_reg       <= neg_next;
        buzz_reg      <= buzz_next;
        vibe_reg      <= vibe_next;
        buzz_out_reg  <= buzz_out_next;
        vibe_out_reg  <= vibe_out_next;
        stab_out_reg  <= stab_out_next;
        pulse_out_reg <= pulse_out_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign buzzer_duty    = buzz_out_reg;
    assign vibration_duty = vibe_out_reg;
    assign object_stable  = stab_out_reg;
    assign alert_pulse    = pulse_out_reg;

endmodule

// ===== hdl/pwd_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pwd_pkg for operand widths.
module pwd_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pwd_pkg::NUM_W-1:0]     dividend,
    input  logic [pwd_pkg::DIST_W-1:0]    divisor,
    output logic                          done,
    output logic [pwd_pkg::NUM_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(pwd_pkg::NUM_W);
    localparam int DW    = pwd_pkg::DIST_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [pwd_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    div_reg, div_next;

    logic [DW:0]      shifted;
    logic [DW+1:0]    trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[pwd_pkg::NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b00, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits DW bits
            if (!trial[DW+1])
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[pwd_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[pwd_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(pwd_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== tb/sv/proximity_warning_driver_test.sv =====
// Self-checking testbench for proximity_warning_driver: directed samples, then random
// sample streams under several register settings, checked against an in-bench predictor.
// Depends on pwd_pkg and the proximity_warning_driver RTL.
module proximity_warning_driver_test;

    localparam int DW = pwd_pkg::DIST_W;
    localparam int UW = pwd_pkg::DUTY_W;

    typedef enum logic [2:0] {SET_KEEP, SET_DEFAULT, SET_EQUAL, SET_INVERTED, SET_WIDE} setting_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

    typedef struct packed {
        logic [pwd_pkg::DIST_W-1:0] danger_cm;
        logic [pwd_pkg::DIST_W-1:0] far_cm;
        logic [pwd_pkg::DIST_W-1:0] delta_cm;
        logic [pwd_pkg::TIME_W-1:0] hold_ms;
        logic [pwd_pkg::TIME_W-1:0] cooldown_ms;
        logic [pwd_pkg::DUTY_W-1:0] buzz_floor;
        logic [pwd_pkg::DUTY_W-1:0] vib_floor;
        logic [pwd_pkg::DUTY_W-1:0] vib_top;
    } warn_cfg_t;

    typedef struct packed {
        logic [pwd_pkg::DUTY_W-1:0] buzz;
        logic [pwd_pkg::DUTY_W-1:0] vibe;
        logic                       stable;
        logic                       pulse;
    } warn_t;

    typedef struct packed {
        setting_t                   setting;
        logic [pwd_pkg::DIST_W-1:0] sample_cm;
        logic [pwd_pkg::TIME_W-1:0] stamp;
        logic                       typed;
        warn_t                      want;
    } step_row_t;

    localparam warn_t NO_DUTY = '0;
    localparam warn_t HELD    = '{8'd0, 8'd0, 1'b1, 1'b0};

    // Rows with typed = 1 carry an expectation that is obvious from the spec;
    // the rest are checked against the predictor.
    step_row_t directed_rows [25] = '{
        '{SET_KEEP,     10'd999,  32'd0,          1'b1, NO_DUTY},
        '{SET_KEEP,     10'd0,    32'd100,        1'b0, NO_DUTY},
        '{SET_KEEP,     10'd0,    32'd60101,      1'b1, HELD},
        '{SET_KEEP,     10'd1023, 32'd60200,      1'b1, NO_DUTY},
        '{SET_KEEP,     10'd5,    32'd70000,      1'b0, NO_DUTY},
        '{SET_KEEP,     10'd10,   32'd70100,      1'b0, NO_DUTY},
        '{SET_KEEP,     10'd200,  32'd70200,      1'b0, NO_DUTY},
        '{SET_KEEP,     10'd201,  32'd70300,      1'b1, NO_DUTY},
        '{SET_KEEP,     10'd50,   32'd70400,      1'b0, NO_DUTY},
        '{SET_KEEP,     10'd51,   32'd70500,      1'b0, NO_DUTY},
        '{SET_KEEP,     10'd30,   32'hFFFF_FF00,  1'b0, NO_DUTY},
        '{SET_KEEP,     10'd30,   32'h0000_0100,  1'b0, NO_DUTY},
        '{SET_KEEP,     10'd30,   32'h0000_1500,  1'b1, HELD},
        '{SET_KEEP,     10'd25,   32'h0000_1600,  1'b1, HELD},
        '{SET_KEEP,     10'd999,  32'h0000_1700,  1'b1, NO_DUTY},
        '{SET_EQUAL,    10'd100,  32'h0000_2000,  1'b0, NO_DUTY},
        '{SET_KEEP,     10'd80,   32'h0000_2100,  1'b0, NO_DUTY},
        '{SET_KEEP,     10'd101,  32'h0000_2200,  1'b0, NO_DUTY},
        '{SET_INVERTED, 10'd100,  32'h0000_3000,  1'b0, NO_DUTY},
        '{SET_KEEP,     10'd40,   32'h0000_3100,  1'b0, NO_DUTY},
        '{SET_KEEP,     10'd150,  32'h0000_3200,  1'b0, NO_DUTY},
        '{SET_WIDE,     10'd0,    32'h0000_4000,  1'b0, NO_DUTY},
        '{SET_KEEP,     10'd999,  32'h0000_4100,  1'b0, NO_DUTY},
        '{SET_KEEP,     10'd500,  32'h0000_4200,  1'b0, NO_DUTY},
        '{SET_DEFAULT,  10'd1000, 32'hFFFF_FFFF,  1'b1, NO_DUTY}
    };

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_we      = 1'b0;
    logic [pwd_pkg::IDX_W-1:0]    cfg_index   = '0;
    logic [pwd_pkg::CFG_W-1:0]    cfg_data    = '0;
    logic                         in_valid    = 1'b0;
    logic [pwd_pkg::DIST_W-1:0]   distance_cm = '0;
    logic [pwd_pkg::TIME_W-1:0]   now_ms      = '0;
    logic                         out_stall   = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic [pwd_pkg::DUTY_W-1:0]   buzzer_duty;
    logic [pwd_pkg::DUTY_W-1:0]   vibration_duty;
    logic                         object_stable;
    logic                         alert_pulse;

    // predictor state and register shadow
    warn_cfg_t                    cfg;
    logic [pwd_pkg::DIST_W-1:0]   anchor_cm;
    logic [pwd_pkg::TIME_W-1:0]   moved_ms;
    logic [pwd_pkg::TIME_W-1:0]   alerted_ms;
    logic                         is_stable;

    warn_t               pending_warnings [$];
    int                  errors          = 0;
    int                  items_sent      = 0;
    int                  results_checked = 0;
    int                  alerts_seen     = 0;
    int                  stable_seen     = 0;
    int                  settings_loaded = 0;

    idle_t               idle_mode = IDLE_NONE;
    logic                hold_go   = 1'b0;
    logic                hold_seen = 1'b0;
    int                  hold_left = 0;

    always #10 clk = ~clk;

    proximity_warning_driver uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .distance_cm    (distance_cm),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .buzzer_duty    (buzzer_duty),
        .vibration_duty (vibration_duty),
        .object_stable  (object_stable),
        .alert_pulse    (alert_pulse)
    );

    function automatic warn_cfg_t preset_settings(input setting_t s);
        case (s)
            SET_EQUAL:    return '{10'd100, 10'd100, 10'd10, 32'd5000, 32'd0,
                                   8'd50, 8'd20, 8'd60};
            SET_INVERTED: return '{10'd300, 10'd100, 10'd10, 32'd5000, 32'd0,
                                   8'd200, 8'd250, 8'd10};
            SET_WIDE:     return '{10'd0, 10'd999, 10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   8'd0, 8'd255, 8'd0};
            default:      return '{10'd50, 10'd200, 10'd10, 32'd5000, 32'd60000,
                                   8'd50, 8'd20, 8'd60};
        endcase
    endfunction

    function automatic warn_cfg_t random_settings();
        warn_cfg_t s;
        int        far;
        s.danger_cm = DW'($urandom_range(0, 300));
        case ($urandom_range(7))
            0:       far = int'(s.danger_cm);
            1:       far = int'($urandom_range(0, s.danger_cm));
            2:       far = 999;
            default: far = int'(s.danger_cm) + int'($urandom_range(1, 500));
        endcase
        s.far_cm = DW'(far);
        if ($urandom_range(9) == 0)
        begin
            s.danger_cm = 10'd998;
            s.far_cm    = 10'd999;
        end
        s.delta_cm = ($urandom_range(7) == 0) ? DW'($urandom_range(0, 1023))
                                              : DW'($urandom_range(0, 20));
        case ($urandom_range(7))
            0:       s.hold_ms = '0;
            1:       s.hold_ms = '1;
            2:       s.hold_ms = $urandom;
            default: s.hold_ms = $urandom_range(0, 3000);
        endcase
        case ($urandom_range(7))
            0:       s.cooldown_ms = '0;
            1:       s.cooldown_ms = '1;
            2:       s.cooldown_ms = $urandom;
            default: s.cooldown_ms = $urandom_range(0, 5000);
        endcase
        s.buzz_floor = UW'($urandom_range(0, 255));
        s.vib_floor  = UW'($urandom_range(0, 255));
        s.vib_top    = UW'($urandom_range(0, 255));
        return s;
    endfunction

    // straight line from far_cm (lo) to danger_cm (hi), truncated toward zero
    function automatic longint line_duty(input longint d, input longint lo, input longint hi);
        longint far;
        longint den;
        far = cfg.far_cm;
        den = longint'(cfg.danger_cm) - far;
        if (den == 0)
            return hi;
        return lo + ((d - far) * (hi - lo)) / den;
    endfunction

    function automatic logic [pwd_pkg::DUTY_W-1:0] clamp_duty(input longint v);
        if (v < 0)
            return '0;
        if (v > pwd_pkg::DUTY_MAX)
            return pwd_pkg::DUTY_MAX;
        return v[pwd_pkg::DUTY_W-1:0];
    endfunction

    function automatic warn_t predict_warning(input logic [pwd_pkg::DIST_W-1:0] d,
                                              input logic [pwd_pkg::TIME_W-1:0] stamp);
        warn_t                      w;
        logic [pwd_pkg::DIST_W-1:0] gap;
        logic [pwd_pkg::TIME_W-1:0] since_move;
        logic [pwd_pkg::TIME_W-1:0] since_alert;
        gap = (d > anchor_cm) ? d - anchor_cm : anchor_cm - d;
        if (gap > cfg.delta_cm)
        begin
            anchor_cm = d;
            moved_ms  = stamp;
            is_stable = 1'b0;
        end
        since_move = stamp - moved_ms;
        if (since_move > cfg.hold_ms)
            is_stable = 1'b1;
        w = '0;
        if (!(d > cfg.far_cm || is_stable))
        begin
            w.buzz = clamp_duty(line_duty(d, cfg.buzz_floor, pwd_pkg::DUTY_MAX));
            if (d <= cfg.danger_cm)
                w.buzz = pwd_pkg::DUTY_MAX;
            w.vibe = clamp_duty(line_duty(d, cfg.vib_floor, cfg.vib_top));
        end
        w.stable = is_stable;
        since_alert = stamp - alerted_ms;
        if (d <= cfg.danger_cm && !is_stable && since_alert > cfg.cooldown_ms)
        begin
            w.pulse    = 1'b1;
            alerted_ms = stamp;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR: result %0d: %s", results_checked, what);
        errors++;
    endtask

    task automatic write_reg(input logic [pwd_pkg::IDX_W-1:0] idx,
                             input logic [pwd_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // junk in the unused upper bits checks that narrow registers are masked
    task automatic load_settings(input warn_cfg_t s);
        logic [pwd_pkg::CFG_W-1:0] junk;
        junk = $urandom;
        write_reg(pwd_pkg::REG_DANGER,
                  {junk[pwd_pkg::CFG_W-1:pwd_pkg::DIST_W], s.danger_cm});
        write_reg(pwd_pkg::REG_MAX,
                  {junk[pwd_pkg::CFG_W-1:pwd_pkg::DIST_W], s.far_cm});
        write_reg(pwd_pkg::REG_DELTA,
                  {junk[pwd_pkg::CFG_W-1:pwd_pkg::DIST_W], s.delta_cm});
        write_reg(pwd_pkg::REG_STIME,    s.hold_ms);
        write_reg(pwd_pkg::REG_COOLDOWN, s.cooldown_ms);
        write_reg(pwd_pkg::REG_BFLOOR,
                  {junk[pwd_pkg::CFG_W-1:pwd_pkg::DUTY_W], s.buzz_floor});
        write_reg(pwd_pkg::REG_VFLOOR,
                  {junk[pwd_pkg::CFG_W-1:pwd_pkg::DUTY_W], s.vib_floor});
        write_reg(pwd_pkg::REG_VCEIL,
                  {junk[pwd_pkg::CFG_W-1:pwd_pkg::DUTY_W], s.vib_top});
        cfg_we <= 1'b0;
        cfg = s;
        settings_loaded++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_warnings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_sample(input logic [pwd_pkg::DIST_W-1:0] d,
                               input logic [pwd_pkg::TIME_W-1:0] stamp,
                               input logic typed, input warn_t typed_want, input idle_t mode);
        warn_t want;
        int    pct;
        pct = (mode == IDLE_SEND) ? 53 : (mode == IDLE_BOTH) ? 14 : 0;
        while ($urandom_range(99) < pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        distance_cm <= d;
        now_ms      <= stamp;
        do
            @(posedge clk);
        while (in_stall);
        want = predict_warning(d, stamp);
        pending_warnings.push_back(typed ? typed_want : want);
        items_sent++;
    endtask

    // result side: check taken transactions, then drive out_stall for the next edge
    always @(posedge clk)
    begin
        warn_t want;
        int    pct;
        if (out_valid && !out_stall)
        begin
            if (pending_warnings.size() == 0)
                report_mismatch($sformatf("transaction with nothing pending (buzzer %0d)",
                                          buzzer_duty));
            else
            begin
                want = pending_warnings.pop_front();
                if (buzzer_duty !== want.buzz)
                    report_mismatch($sformatf("buzzer_duty %0d, expected %0d",
                                              buzzer_duty, want.buzz));
                if (vibration_duty !== want.vibe)
                    report_mismatch($sformatf("vibration_duty %0d, expected %0d",
                                              vibration_duty, want.vibe));
                if (object_stable !== want.stable)
                    report_mismatch($sformatf("object_stable %0b, expected %0b",
                                              object_stable, want.stable));
                if (alert_pulse !== want.pulse)
                    report_mismatch($sformatf("alert_pulse %0b, expected %0b",
                                              alert_pulse, want.pulse));
                alerts_seen += want.pulse;
                stable_seen += want.stable;
            end
            results_checked++;
        end
        pct = (idle_mode == IDLE_RECV) ? 53 : (idle_mode == IDLE_BOTH) ? 14 : 0;
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < pct);
    end

    initial
    begin
        step_row_t                  row;
        warn_cfg_t                  plan;
        idle_t                      phase_mode;
        int                         walk_d;
        logic [pwd_pkg::TIME_W-1:0] clock_ms;
        cfg        = preset_settings(SET_DEFAULT);
        anchor_cm  = pwd_pkg::NO_ECHO_CM;
        moved_ms   = '0;
        alerted_ms = '0;
        is_stable  = 1'b0;
        phase_mode = IDLE_NONE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.setting != SET_KEEP)
            begin
                wait_idle();
                load_settings(preset_settings(row.setting));
            end
            send_sample(row.sample_cm, row.stamp, row.typed, row.want, phase_mode);
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            plan = random_settings();
            load_settings(plan);
            phase_mode = idle_t'(phase % 4);
            idle_mode <= phase_mode;
            // long receiver hold-off so the block backs up into its input
            if (phase == 0 || phase == 5)
                hold_go <= ~hold_go;
            clock_ms = (phase % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 100000) : $urandom;
            walk_d = int'($urandom_range(0, plan.far_cm));
            for (int k = 0; k < 160; k++)
            begin
                // mostly a slowly moving object, with jumps, no-echo and odd readings
                case ($urandom_range(19))
                    0:       walk_d = int'(pwd_pkg::NO_ECHO_CM);
                    1:       walk_d = int'($urandom_range(1000, 1023));
                    2, 3:    walk_d = int'($urandom_range(0, 1023));
                    4, 5:    walk_d = int'($urandom_range(0, plan.far_cm));
                    default: walk_d = walk_d + int'($urandom_range(0, 16)) - 9;
                endcase
                if (walk_d < 0)
                    walk_d = 0;
                if (walk_d > 1023)
                    walk_d = 1023;
                case ($urandom_range(29))
                    0:       clock_ms = $urandom;
                    1:       clock_ms = clock_ms + $urandom_range(0, 20000);
                    default: clock_ms = clock_ms + $urandom_range(0, 400);
                endcase
                send_sample(walk_d[pwd_pkg::DIST_W-1:0], clock_ms, 1'b0, NO_DUTY, phase_mode);
            end
        end

        wait_idle();
        idle_mode <= IDLE_NONE;
        repeat (60) @(posedge clk);
        $display("Summary: %0d samples sent, %0d results checked, %0d register settings used",
                 items_sent, results_checked, settings_loaded);
        $display("Summary: %0d alert pulses and %0d stable results among them",
                 alerts_seen, stable_seen);
        if (errors == 0 && pending_warnings.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TIMEOUT: %0d results still pending", pending_warnings.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
